@@ design/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttb_pkg: shared types for the triangle tangent basis core
// Payload structs, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int unsigned DeltaW  = 17;  // position/texture delta
  localparam int unsigned ProdW   = 34;  // one delta product
  localparam int unsigned AccW    = 35;  // difference of two products
  localparam int unsigned MagW    = 34;  // component magnitude
  localparam int unsigned NormW   = 20;  // magnitude after normalising shift
  localparam int unsigned SumW    = 42;  // sum of squares
  localparam int unsigned RootW   = 44;  // root iteration registers
  localparam int unsigned RW      = 21;  // final root
  localparam int unsigned NumW    = 36;  // division numerator
  localparam int unsigned QuoW    = 15;  // quotient magnitude
  localparam int unsigned SqrtSteps = 22;
  localparam int unsigned DivSteps  = 15;
  localparam int unsigned LastProduct = 6;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic               tex_present;
  } corner_t;

  typedef struct packed {
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [15:0] bitan_x;
    logic signed [15:0] bitan_y;
    logic signed [15:0] bitan_z;
    logic               degenerate;
  } basis_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_MUL,
    ST_LOAD,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_STORE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       cap0;
    logic       cap1;
    logic       cap2;
    logic [2:0] mul_j;
    logic       mul_ph;
    logic       load;
    logic       vec;
    logic       shift;
    logic       sq;
    logic [1:0] idx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic [3:0] div_k;
    logic       store;
    logic       set_deg;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic in_range;
  } status_t;

endpackage

@@ design/ttb_if.sv @@
// ----------------------------------------------------------------------------
// ttb_if: valid/ready channels of the triangle tangent basis core
// One interface for corner transactions, one for result transactions.
// ----------------------------------------------------------------------------
interface ttb_corner_if;
  logic             valid;
  logic             ready;
  ttb_pkg::corner_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttb_basis_if;
  logic            valid;
  logic            ready;
  ttb_pkg::basis_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/ttb_datapath.sv @@
// ----------------------------------------------------------------------------
// ttb_datapath: arithmetic of the triangle tangent basis core
// Corner store, shared multiplier, normalising shifter, root and divider.
// ----------------------------------------------------------------------------
module ttb_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ttb_pkg::corner_t corner_i,
  input  ttb_pkg::cmd_t    cmd_i,
  output ttb_pkg::status_t status_o,
  output ttb_pkg::basis_t  basis_o
);

  localparam int unsigned DW = ttb_pkg::DeltaW;
  localparam int unsigned PW = ttb_pkg::ProdW;
  localparam int unsigned AW = ttb_pkg::AccW;
  localparam int unsigned MW = ttb_pkg::MagW;
  localparam int unsigned NW = ttb_pkg::NormW;
  localparam int unsigned SW = ttb_pkg::SumW;
  localparam int unsigned QW = ttb_pkg::RootW;
  localparam int unsigned RW = ttb_pkg::RW;
  localparam int unsigned UW = ttb_pkg::NumW;
  localparam int unsigned OW = ttb_pkg::QuoW;

  logic signed [15:0]   pin [3];
  logic signed [15:0]   tin [2];
  logic signed [15:0]   p0_q [3], p1_q [3];
  logic signed [15:0]   t0_q [2], t1_q [2];
  logic                 pr0_q, pr1_q;
  logic signed [DW-1:0] dp1_q [3], dp2_q [3];
  logic signed [DW-1:0] dv1_q [2], dv2_q [2];
  logic                 tex_all;

  assign pin[0] = corner_i.pos_x;
  assign pin[1] = corner_i.pos_y;
  assign pin[2] = corner_i.pos_z;
  assign tin[0] = corner_i.tex_u;
  assign tin[1] = corner_i.tex_v;
  assign tex_all = corner_i.tex_present & pr0_q & pr1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap0) begin
      p0_q  <= pin;
      t0_q  <= tin;
      pr0_q <= corner_i.tex_present;
    end
    if (cmd_i.cap1) begin
      p1_q  <= pin;
      t1_q  <= tin;
      pr1_q <= corner_i.tex_present;
    end
    if (cmd_i.cap2) begin
      for (int i = 0; i < 3; i++) begin
        dp1_q[i] <= DW'(pin[i]) - DW'(p0_q[i]);
        dp2_q[i] <= DW'(p1_q[i]) - DW'(p0_q[i]);
      end
    end
  end

  // texture deltas of the last fully textured face
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv1_q <= '{default: '0};
      dv2_q <= '{default: '0};
    end else if (cmd_i.cap2 && tex_all) begin
      for (int i = 0; i < 2; i++) begin
        dv1_q[i] <= DW'(tin[i]) - DW'(t0_q[i]);
        dv2_q[i] <= DW'(t1_q[i]) - DW'(t0_q[i]);
      end
    end
  end

  // shared multiplier: det, tangent, bitangent as a*b - c*d, a*b registered first
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod, prod_q;
  logic signed [AW-1:0] res_q [7];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_j)
      3'd0: begin
        op_a = cmd_i.mul_ph ? dv1_q[1] : dv1_q[0];
        op_b = cmd_i.mul_ph ? dv2_q[0] : dv2_q[1];
      end
      3'd1, 3'd2, 3'd3: begin
        op_a = cmd_i.mul_ph ? dp2_q[cmd_i.mul_j[1:0] - 2'd1] : dp1_q[cmd_i.mul_j[1:0] - 2'd1];
        op_b = cmd_i.mul_ph ? dv1_q[1] : dv2_q[1];
      end
      3'd4: begin
        op_a = cmd_i.mul_ph ? dp1_q[0] : dp2_q[0];
        op_b = cmd_i.mul_ph ? dv2_q[0] : dv1_q[0];
      end
      3'd5: begin
        op_a = cmd_i.mul_ph ? dp1_q[1] : dp2_q[1];
        op_b = cmd_i.mul_ph ? dv2_q[0] : dv1_q[0];
      end
      3'd6: begin
        op_a = cmd_i.mul_ph ? dp1_q[2] : dp2_q[2];
        op_b = cmd_i.mul_ph ? dv2_q[0] : dv1_q[0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (!cmd_i.mul_ph) prod_q <= prod;
    if (cmd_i.mul_ph && cmd_i.mul_j <= 3'(ttb_pkg::LastProduct)) begin
      res_q[cmd_i.mul_j] <= AW'(prod_q) - AW'(prod);
    end
  end

  // vector selection and magnitudes
  logic signed [AW-1:0] sel [3];
  logic [MW-1:0]        mag [3];
  logic [MW-1:0]        mag_max;
  logic                 det_neg;

  assign det_neg = res_q[0][AW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sel[i] = cmd_i.vec ? res_q[4+i] : res_q[1+i];
      mag[i] = sel[i][AW-1] ? MW'(-sel[i]) : MW'(sel[i]);
    end
    mag_max = mag[0];
    if (mag[1] > mag_max) mag_max = mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
  end

  logic [MW-1:0] m_q [3];
  logic [MW-1:0] mx_q;
  logic          neg_q [3];
  logic          too_big;

  assign too_big = |mx_q[MW-1:NW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q  <= mag;
      mx_q <= mag_max;
      for (int i = 0; i < 3; i++) neg_q[i] <= sel[i][AW-1] ^ det_neg;
    end else if (cmd_i.shift) begin
      if (too_big) begin
        for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        mx_q <= mx_q >> 1;
      end else begin
        for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        mx_q <= mx_q << 1;
      end
    end
  end

  // sum of squares
  logic [NW-1:0]   m_sel;
  logic [2*NW-1:0] sq;
  logic [SW-1:0]   s_q;

  assign m_sel = m_q[cmd_i.idx][NW-1:0];
  assign sq    = m_sel * m_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) s_q <= ((cmd_i.idx == 2'd0) ? '0 : s_q) + SW'(sq);
  end

  // bitwise integer square root
  logic [SW-1:0] rem_q;
  logic [QW-1:0] root_q, bit_q, trial;

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rem_q  <= s_q;
      root_q <= '0;
      bit_q  <= QW'(1) << (2 * (ttb_pkg::SqrtSteps - 1));
    end else if (cmd_i.sqrt_step) begin
      if (QW'(rem_q) >= trial) begin
        rem_q  <= rem_q - SW'(trial);
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [RW-1:0]   r;
  logic [RW:0]     den;
  logic [UW:0]     den_k;
  logic [UW-1:0]   num_q;
  logic [OW-1:0]   quo_q;

  assign r     = root_q[RW-1:0];
  assign den   = {r, 1'b0};
  assign den_k = (UW+1)'(den) << cmd_i.div_k;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      num_q <= UW'({m_sel, 15'b0}) + UW'(r);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if ((UW+1)'(num_q) >= den_k) begin
        num_q                <= num_q - UW'(den_k);
        quo_q[cmd_i.div_k]   <= 1'b1;
      end
    end
  end

  // result registers
  logic signed [15:0] tan_q [3], btn_q [3];
  logic signed [15:0] val;
  logic               deg_q;

  assign val = neg_q[cmd_i.idx] ? -16'(quo_q) : 16'(quo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      if (cmd_i.vec) btn_q[cmd_i.idx] <= val;
      else           tan_q[cmd_i.idx] <= val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            deg_q <= 1'b0;
    else if (cmd_i.set_deg) deg_q <= 1'b1;
    else if (cmd_i.cap2)    deg_q <= 1'b0;
  end

  assign status_o.det_zero = (res_q[0] == '0);
  assign status_o.vec_zero = (mag_max == '0);
  assign status_o.in_range = (mx_q[MW-1:NW-1] == (MW-NW+1)'(1));

  assign basis_o.tan_x      = deg_q ? '0 : tan_q[0];
  assign basis_o.tan_y      = deg_q ? '0 : tan_q[1];
  assign basis_o.tan_z      = deg_q ? '0 : tan_q[2];
  assign basis_o.bitan_x    = deg_q ? '0 : btn_q[0];
  assign basis_o.bitan_y    = deg_q ? '0 : btn_q[1];
  assign basis_o.bitan_z    = deg_q ? '0 : btn_q[2];
  assign basis_o.degenerate = deg_q;

endmodule

@@ design/ttb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttb_ctrl: sequencer of the triangle tangent basis core
// Counts corners, steps the datapath through one face, owns the handshakes.
// ----------------------------------------------------------------------------
module ttb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ttb_pkg::status_t status_i,
  output ttb_pkg::cmd_t    cmd_o
);

  ttb_pkg::state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] j_q, j_d;
  logic       ph_q, ph_d;
  logic       vec_q, vec_d;
  logic [1:0] idx_q, idx_d;
  logic [4:0] it_q, it_d;
  logic       out_valid_q, out_valid_d;
  logic       acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttb_pkg::ST_COLLECT;
      cnt_q       <= '0;
      j_q         <= '0;
      ph_q        <= 1'b0;
      vec_q       <= 1'b0;
      idx_q       <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      ph_q        <= ph_d;
      vec_q       <= vec_d;
      idx_q       <= idx_d;
      it_q        <= it_d;
      out_valid_q <= out_valid_d;
    end
  end

  // third corner waits until the previous result has gone
  assign in_ready_o  = (state_q == ttb_pkg::ST_COLLECT) && !(cnt_q == 2'd2 && out_valid_q);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    ph_d        = ph_q;
    vec_d       = vec_q;
    idx_d       = idx_q;
    it_d        = it_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o        = '0;
    cmd_o.mul_j  = j_q;
    cmd_o.mul_ph = ph_q;
    cmd_o.vec    = vec_q;
    cmd_o.idx    = idx_q;
    cmd_o.div_k  = it_q[3:0];
    case (state_q)
      ttb_pkg::ST_COLLECT: begin
        if (acc) begin
          case (cnt_q)
            2'd0: begin
              cmd_o.cap0 = 1'b1;
              cnt_d      = 2'd1;
            end
            2'd1: begin
              cmd_o.cap1 = 1'b1;
              cnt_d      = 2'd2;
            end
            default: begin
              cmd_o.cap2 = 1'b1;
              cnt_d      = 2'd0;
              j_d        = '0;
              ph_d       = 1'b0;
              state_d    = ttb_pkg::ST_MUL;
            end
          endcase
        end
      end
      ttb_pkg::ST_MUL: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (j_q == 3'(ttb_pkg::LastProduct)) begin
            if (status_i.det_zero) begin
              cmd_o.set_deg = 1'b1;
              state_d       = ttb_pkg::ST_FIN;
            end else begin
              vec_d   = 1'b0;
              state_d = ttb_pkg::ST_LOAD;
            end
          end else begin
            j_d = j_q + 3'd1;
          end
        end
      end
      ttb_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (status_i.vec_zero) begin
          cmd_o.set_deg = 1'b1;
          state_d       = ttb_pkg::ST_FIN;
        end else begin
          state_d = ttb_pkg::ST_SHIFT;
        end
      end
      ttb_pkg::ST_SHIFT: begin
        if (status_i.in_range) begin
          idx_d   = 2'd0;
          state_d = ttb_pkg::ST_SQ;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      ttb_pkg::ST_SQ: begin
        cmd_o.sq = 1'b1;
        if (idx_q == 2'd2) state_d = ttb_pkg::ST_SQRT_INIT;
        else               idx_d   = idx_q + 2'd1;
      end
      ttb_pkg::ST_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        it_d            = '0;
        state_d         = ttb_pkg::ST_SQRT;
      end
      ttb_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (it_q == 5'(ttb_pkg::SqrtSteps - 1)) begin
          idx_d   = 2'd0;
          state_d = ttb_pkg::ST_DIV_INIT;
        end else begin
          it_d = it_q + 5'd1;
        end
      end
      ttb_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        it_d           = 5'(ttb_pkg::DivSteps - 1);
        state_d        = ttb_pkg::ST_DIV;
      end
      ttb_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (it_q == '0) state_d = ttb_pkg::ST_STORE;
        else            it_d    = it_q - 5'd1;
      end
      ttb_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        if (idx_q == 2'd2) begin
          if (vec_q) begin
            state_d = ttb_pkg::ST_FIN;
          end else begin
            vec_d   = 1'b1;
            state_d = ttb_pkg::ST_LOAD;
          end
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ttb_pkg::ST_DIV_INIT;
        end
      end
      ttb_pkg::ST_FIN: begin
        out_valid_d = 1'b1;
        state_d     = ttb_pkg::ST_COLLECT;
      end
      default: begin
        state_d = ttb_pkg::ST_COLLECT;
      end
    endcase
  end

  a_face_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cnt_q == 2'd2) |=> (state_q == ttb_pkg::ST_MUL))
    else $error("third corner did not start the face computation");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ttb_pkg::ST_FIN))
    else $error("result raised outside the finishing step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ttb_pkg::ST_FIN) |-> !out_valid_q)
    else $error("pending result would be overwritten");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ttb_pkg::ST_DIV) |-> (it_q <= 5'(ttb_pkg::DivSteps - 1)))
    else $error("divider bit index out of range");

endmodule

@@ design/triangle_tangent_basis_core.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_basis_core: per-triangle unit tangent and bitangent
// Takes corners three at a time and returns one Q1.14 basis per face.
// ----------------------------------------------------------------------------
// Corners arrive as single transactions; the first two of a face are taken
// in one cycle each, also while the previous result still waits, and the
// third is taken once that result has gone. After the third corner the face
// occupies the block for the products of det, tangent and bitangent on the
// single shared 17x17 multiplier; unless the determinant or a vector is zero
// it then runs, per vector, a load, one-bit normalising shifts, squaring, a
// bitwise square root and a restoring division of each component, and ends
// with the step that raises the result. A result is held in the output
// register until its transaction completes.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  ttb_corner_if.sink  corner_i,
  ttb_basis_if.source basis_o
);

  ttb_pkg::cmd_t    cmd;
  ttb_pkg::status_t status;
  ttb_pkg::basis_t  basis;

  // sequencer: corner count, face steps, both handshakes
  ttb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corner_i.valid),
    .in_ready_o  (corner_i.ready),
    .out_valid_o (basis_o.valid),
    .out_ready_i (basis_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, corner store and result registers
  ttb_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .corner_i (corner_i.data),
    .cmd_i    (cmd),
    .status_o (status),
    .basis_o  (basis)
  );

  assign basis_o.data = basis;

endmodule

@@ test/tb_pkg_note.sv @@
// ----------------------------------------------------------------------------
// tb_corner_gen: corner value helpers for the tangent basis testbench
// Random field values skewed towards the extremes of the signed range and small values around zero.
// ----------------------------------------------------------------------------
package tb_corner_gen;

  function automatic logic signed [15:0] pick16();
    case ($urandom_range(0, 7))
      0: pick16 = 16'sh7fff;
      1: pick16 = 16'sh8000;
      2: pick16 = 16'($urandom_range(0, 15)) - 16'sd8;
      default: pick16 = 16'($urandom);
    endcase
  endfunction

endpackage

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for triangle_tangent_basis_core
// Streams corners through the block, predicts each face's unit tangent and
// bitangent in integer arithmetic and checks every result transaction.
// ----------------------------------------------------------------------------
module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  ttb_corner_if corner_ch ();
  ttb_basis_if  basis_ch ();

  triangle_tangent_basis_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .corner_i(corner_ch.sink),
    .basis_o (basis_ch.source)
  );

  // predictor state
  int unsigned       face_corner;
  ttb_pkg::corner_t  held_corner [2];
  longint            duv1 [2];
  longint            duv2 [2];
  ttb_pkg::basis_t   basis_q [$];
  int unsigned       fail_count;
  bit                sink_stall_en;
  bit                src_idle_en;

  function automatic longint isqrt(longint s);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > s) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - res - bitv;
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Normalise to Q1.14; returns 0 for a zero vector.
  function automatic bit to_unit(input longint c [3], output logic signed [15:0] q [3]);
    longint m [3];
    longint mx, s, r, mag;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
      q[i] = '0;
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'sd1 << 20)) begin
      mx = mx >>> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
    end
    while (mx < (64'sd1 << 19)) begin
      mx = mx <<< 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    r = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      mag = (32768 * m[i] + r) / (2 * r);
      q[i] = 16'(c[i] < 0 ? -mag : mag);
    end
    return 1'b1;
  endfunction

  // Models one accepted corner; every third one queues a basis.
  function automatic void predict_corner(ttb_pkg::corner_t c);
    longint dp1 [3], dp2 [3], tg [3], bt [3], p [3], p0 [3], p1 [3];
    logic signed [15:0] qt [3], qb [3];
    longint det;
    bit ok;
    ttb_pkg::basis_t b;
    if (face_corner < 2) begin
      held_corner[face_corner] = c;
      face_corner++;
      return;
    end
    face_corner = 0;
    if (c.tex_present && held_corner[0].tex_present && held_corner[1].tex_present) begin
      duv1[0] = longint'(c.tex_u) - held_corner[0].tex_u;
      duv1[1] = longint'(c.tex_v) - held_corner[0].tex_v;
      duv2[0] = longint'(held_corner[1].tex_u) - held_corner[0].tex_u;
      duv2[1] = longint'(held_corner[1].tex_v) - held_corner[0].tex_v;
    end
    p  = '{c.pos_x, c.pos_y, c.pos_z};
    p0 = '{held_corner[0].pos_x, held_corner[0].pos_y, held_corner[0].pos_z};
    p1 = '{held_corner[1].pos_x, held_corner[1].pos_y, held_corner[1].pos_z};
    det = duv1[0] * duv2[1] - duv1[1] * duv2[0];
    for (int i = 0; i < 3; i++) begin
      dp1[i] = p[i] - p0[i];
      dp2[i] = p1[i] - p0[i];
      tg[i] = dp1[i] * duv2[1] - dp2[i] * duv1[1];
      bt[i] = dp2[i] * duv1[0] - dp1[i] * duv2[0];
      if (det < 0) begin
        tg[i] = -tg[i];
        bt[i] = -bt[i];
      end
    end
    ok = det != 0;
    if (ok) ok = to_unit(tg, qt);
    if (ok) ok = to_unit(bt, qb);
    b.tan_x = ok ? qt[0] : '0;
    b.tan_y = ok ? qt[1] : '0;
    b.tan_z = ok ? qt[2] : '0;
    b.bitan_x = ok ? qb[0] : '0;
    b.bitan_y = ok ? qb[1] : '0;
    b.bitan_z = ok ? qb[2] : '0;
    b.degenerate = !ok;
    basis_q.push_back(b);
  endfunction

  // Drives one corner transaction, with an optional random idle burst first.
  // Valid stays high after the transaction so the next corner can follow.
  task automatic send_corner(ttb_pkg::corner_t c);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      corner_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    corner_ch.valid <= 1'b1;
    corner_ch.data  <= c;
    do @(posedge clk_i); while (!corner_ch.ready);
    predict_corner(c);
  endtask

  // Drops valid after the last corner of a stream.
  task automatic stop_source();
    corner_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic ttb_pkg::corner_t make_corner(logic signed [15:0] x, y, z, u, v,
                                                   bit tp);
    ttb_pkg::corner_t c;
    c.pos_x = x;
    c.pos_y = y;
    c.pos_z = z;
    c.tex_u = u;
    c.tex_v = v;
    c.tex_present = tp;
    return c;
  endfunction

  function automatic ttb_pkg::corner_t rand_corner(bit tp);
    return make_corner(tb_corner_gen::pick16(), tb_corner_gen::pick16(),
                       tb_corner_gen::pick16(), tb_corner_gen::pick16(),
                       tb_corner_gen::pick16(), tp);
  endfunction

  task automatic wait_drained();
    while (basis_q.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: ready stalls in bursts, compare on each transaction.
  always @(posedge clk_i) begin
    ttb_pkg::basis_t exp_b, got;
    if (rst_ni) begin
      if (basis_ch.valid && basis_ch.ready) begin
        got = basis_ch.data;
        if (basis_q.size() == 0) begin
          $error("result with no face pending");
          fail_count++;
        end else begin
          exp_b = basis_q.pop_front();
          if (got.tan_x !== exp_b.tan_x) begin
            $error("tan_x exp %0d got %0d", exp_b.tan_x, got.tan_x); fail_count++;
          end
          if (got.tan_y !== exp_b.tan_y) begin
            $error("tan_y exp %0d got %0d", exp_b.tan_y, got.tan_y); fail_count++;
          end
          if (got.tan_z !== exp_b.tan_z) begin
            $error("tan_z exp %0d got %0d", exp_b.tan_z, got.tan_z); fail_count++;
          end
          if (got.bitan_x !== exp_b.bitan_x) begin
            $error("bitan_x exp %0d got %0d", exp_b.bitan_x, got.bitan_x); fail_count++;
          end
          if (got.bitan_y !== exp_b.bitan_y) begin
            $error("bitan_y exp %0d got %0d", exp_b.bitan_y, got.bitan_y); fail_count++;
          end
          if (got.bitan_z !== exp_b.bitan_z) begin
            $error("bitan_z exp %0d got %0d", exp_b.bitan_z, got.bitan_z); fail_count++;
          end
          if (got.degenerate !== exp_b.degenerate) begin
            $error("degenerate exp %0d got %0d", exp_b.degenerate, got.degenerate);
            fail_count++;
          end
        end
      end
    end
  end

  // Ready pattern: random stall bursts, or always ready.
  initial begin
    int burst;
    basis_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        basis_ch.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk_i);
      end else begin
        basis_ch.ready <= 1'b1;
      end
    end
  end

  // Directed faces: extremes, a simple right-angled face, missing texture
  // coordinates, zero and positive determinants and zero-length vectors.
  task automatic test_directed();
    ttb_pkg::corner_t f [$];
    // plain face in the xy plane, uv aligned
    f.push_back(make_corner(0, 0, 0, 0, 0, 1));
    f.push_back(make_corner(256, 0, 0, 4096, 0, 1));
    f.push_back(make_corner(0, 256, 0, 0, 4096, 1));
    // full-scale extremes
    f.push_back(make_corner(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1));
    f.push_back(make_corner(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1));
    f.push_back(make_corner(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 1));
    // missing texture coordinate: reuse the previous deltas
    f.push_back(make_corner(10, 20, 30, 1, 2, 0));
    f.push_back(make_corner(-5, 7, 9, -1, -1, 1));
    f.push_back(make_corner(3, -8, 100, -1, -1, 1));
    // zero determinant (collinear uv)
    f.push_back(make_corner(1, 2, 3, 0, 0, 1));
    f.push_back(make_corner(4, 5, 6, 100, 100, 1));
    f.push_back(make_corner(7, 9, 1, 200, 200, 1));
    // zero-length vectors: all positions equal
    f.push_back(make_corner(-1, -1, -1, 0, 0, 1));
    f.push_back(make_corner(-1, -1, -1, 4096, 0, 1));
    f.push_back(make_corner(-1, -1, -1, 0, 4096, 1));
    // positive determinant
    f.push_back(make_corner(0, 0, 0, 0, 0, 1));
    f.push_back(make_corner(0, 300, 0, 4096, 0, 1));
    f.push_back(make_corner(300, 0, 0, 0, -4096, 1));
    foreach (f[i]) send_corner(f[i]);
  endtask

  // Random faces, mostly fully textured, some with a missing coordinate.
  task automatic test_random(int unsigned n_faces);
    for (int unsigned k = 0; k < n_faces; k++)
      for (int j = 0; j < 3; j++) send_corner(rand_corner($urandom_range(0, 9) != 0));
  endtask

  initial begin
    corner_ch.valid <= 1'b0;
    corner_ch.data  <= '0;
    face_corner = 0;
    duv1 = '{0, 0};
    duv2 = '{0, 0};
    fail_count = 0;
    sink_stall_en = 1'b1;
    src_idle_en = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    stop_source();
    wait_drained();        // sender holds off until every face is back
    test_random(120);
    sink_stall_en = 1'b0;  // last stretch runs with no idling
    src_idle_en = 1'b0;
    test_random(45);
    stop_source();
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: allows for ~180 faces at their longest, several times over.
  initial begin
    #(20 * 400000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
design/ttb_pkg.sv
design/ttb_if.sv
design/ttb_datapath.sv
design/ttb_ctrl.sv
design/triangle_tangent_basis_core.sv
test/tb_pkg_note.sv
test/tb.sv
